// ----- sv/aet_pkg.sv -----
// aet_pkg: shared types, codes and helpers of the arithmetic expression tokenizer
// used by aet_lexer, aet_outq and arith_expression_tokenizer_core; no dependencies
package aet_pkg;

  localparam int LINE_W  = 16;
  localparam int COL_W   = 12;
  localparam int TALLY_W = 6;
  localparam int ILIM_W  = 6;
  localparam int ELIM_W  = 4;
  localparam int MAX_RES = 3;
  localparam int CNT_W   = 2;
  localparam int ADDR_W  = 1;
  localparam int DATA_W  = 48;

  localparam logic [LINE_W-1:0]  LINE_MAX  = '1;
  localparam logic [LINE_W-1:0]  LINE_ONE  = LINE_W'(1);
  localparam logic [COL_W-1:0]   COL_MAX   = '1;
  localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

  // configuration register indexes
  localparam logic [ADDR_W-1:0] REG_INT_LIMIT = 1'b0;
  localparam logic [ADDR_W-1:0] REG_EXP_LIMIT = 1'b1;

  localparam logic [ILIM_W-1:0] INT_LIMIT_RST = 6'd18;
  localparam logic [ELIM_W-1:0] EXP_LIMIT_RST = 4'd3;

  // token kinds
  localparam logic [3:0] KIND_NONE = 4'd0;
  localparam logic [3:0] K_NEWLINE = 4'd0;
  localparam logic [3:0] K_PLUS    = 4'd1;
  localparam logic [3:0] K_MINUS   = 4'd2;
  localparam logic [3:0] K_STAR    = 4'd3;
  localparam logic [3:0] K_SLASH   = 4'd4;
  localparam logic [3:0] K_PERCENT = 4'd5;
  localparam logic [3:0] K_LPAREN  = 4'd6;
  localparam logic [3:0] K_RPAREN  = 4'd7;
  localparam logic [3:0] K_INTEGER = 4'd8;
  localparam logic [3:0] K_FLOAT   = 4'd9;
  localparam logic [3:0] K_END     = 4'd10;

  // error codes
  localparam logic [2:0] CODE_NONE      = 3'd0;
  localparam logic [2:0] E_UNRECOGNIZED = 3'd0;
  localparam logic [2:0] E_EOL_RADIX    = 3'd1;
  localparam logic [2:0] E_BAD_RADIX    = 3'd2;
  localparam logic [2:0] E_EOL_EXP      = 3'd3;
  localparam logic [2:0] E_BAD_EXP      = 3'd4;
  localparam logic [2:0] E_TOO_LARGE    = 3'd5;
  localparam logic [2:0] E_SEPARATOR    = 3'd6;

  // characters
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_US     = 8'h5F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_E_LO   = 8'h65;
  localparam logic [7:0] CH_E_UP   = 8'h45;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_BS     = 8'h08;

  // one result beat, first field in the highest bits
  typedef struct packed {
    logic [COL_W-1:0]  length;
    logic [COL_W-1:0]  column;
    logic [LINE_W-1:0] line_number;
    logic [2:0]        error_code;
    logic [3:0]        kind;
    logic              is_error;
  } res_t;

  function automatic logic [COL_W-1:0] col_inc(input logic [COL_W-1:0] v);
    return (v == COL_MAX) ? v : COL_W'(v + 1'b1);
  endfunction

  function automatic res_t mk_res(input logic              is_err,
                                  input logic [3:0]        kind,
                                  input logic [2:0]        code,
                                  input logic [LINE_W-1:0] line,
                                  input logic [COL_W-1:0]  col,
                                  input logic [COL_W-1:0]  len);
    res_t r;
    r.is_error    = is_err;
    r.kind        = kind;
    r.error_code  = code;
    r.line_number = line;
    r.column      = col;
    r.length      = len;
    return r;
  endfunction

endpackage

// ----- sv/aet_lexer.sv -----
// aet_lexer: scanner state registers and the per-character decode that
// yields up to three result beats per character; depends on aet_pkg
module aet_lexer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_fire,
  input  logic [7:0]                  ch,
  input  logic                        le,
  input  logic                        eoi,
  input  logic [aet_pkg::ILIM_W-1:0]  int_lim,
  input  logic [aet_pkg::ELIM_W-1:0]  exp_lim,
  output aet_pkg::res_t               res [aet_pkg::MAX_RES],
  output logic [aet_pkg::CNT_W-1:0]   res_n
);
  import aet_pkg::*;

  localparam logic [2:0] M_IDLE  = 3'd0;
  localparam logic [2:0] M_INT   = 3'd1;
  localparam logic [2:0] M_DOT   = 3'd2;
  localparam logic [2:0] M_FRAC  = 3'd3;
  localparam logic [2:0] M_EMARK = 3'd4;
  localparam logic [2:0] M_SIGN  = 3'd5;
  localparam logic [2:0] M_EXP   = 3'd6;
  localparam logic [2:0] M_SKIP  = 3'd7;

  localparam logic [1:0] F_INT = 2'd0;
  localparam logic [1:0] F_FLT = 2'd1;
  localparam logic [1:0] F_EXP = 2'd2;

  logic [2:0]         mode_r,  mode_nxt;
  logic [LINE_W-1:0]  line_r,  line_nxt;
  logic [COL_W-1:0]   col_r,   col_nxt;
  logic [COL_W-1:0]   ts_r,    ts_nxt;
  logic [COL_W-1:0]   exps_r,  exps_nxt;
  logic [TALLY_W-1:0] tally_r, tally_nxt;
  logic               pwd_r,   pwd_nxt;

  logic [COL_W-1:0]   p, e1, ep, fin_len;
  logic               dig, run, blank, in_run, sep_bad;
  logic [TALLY_W-1:0] tally_abs, tally_use;
  logic               int_big, exp_big;
  logic               op_v;
  logic [3:0]         op_kind;

  logic               sep_v, pri_v, pri_fin, idle_go, end_v, idle_v, tail_v;
  logic [1:0]         fin_sel;
  logic [2:0]         pri_code;
  logic [COL_W-1:0]   pri_pos;
  res_t               r_sep, r_pri, r_fin, r_idle, r_tail;

  assign p      = col_r;
  assign e1     = col_inc(col_r);
  assign dig    = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign run    = dig || (ch == CH_US);
  assign blank  = (ch == CH_SP) || (ch == CH_TAB) || (ch == CH_CR) ||
                  (ch == CH_VT) || (ch == CH_BEL) || (ch == CH_BS);
  assign in_run = run && !eoi;

  // digit run continues: finish at the line end; otherwise at this position
  assign ep      = in_run ? e1 : p;
  assign sep_bad = in_run ? !dig : !pwd_r;

  assign tally_abs = (dig && (tally_r != TALLY_MAX)) ? TALLY_W'(tally_r + 1'b1) : tally_r;
  assign tally_use = eoi ? tally_r : tally_abs;
  assign int_big   = tally_use > int_lim;
  assign exp_big   = tally_use > TALLY_W'(exp_lim);
  assign fin_len   = COL_W'(ep - ts_r);

  always_comb begin
    op_v    = 1'b1;
    op_kind = K_NEWLINE;
    unique case (ch)
      CH_NL:     op_kind = K_NEWLINE;
      CH_PLUS:   op_kind = K_PLUS;
      CH_MINUS:  op_kind = K_MINUS;
      CH_STAR:   op_kind = K_STAR;
      CH_SLASH:  op_kind = K_SLASH;
      CH_PCT:    op_kind = K_PERCENT;
      CH_LPAREN: op_kind = K_LPAREN;
      CH_RPAREN: op_kind = K_RPAREN;
      default:   op_v    = 1'b0;
    endcase
  end

  // scan decision
  always_comb begin
    mode_nxt  = mode_r;
    ts_nxt    = ts_r;
    tally_nxt = tally_r;
    pwd_nxt   = pwd_r;
    exps_nxt  = exps_r;
    line_nxt  = line_r;
    col_nxt   = col_r;
    sep_v     = 1'b0;
    pri_v     = 1'b0;
    pri_fin   = 1'b0;
    fin_sel   = F_INT;
    pri_code  = E_UNRECOGNIZED;
    pri_pos   = p;
    idle_go   = 1'b0;
    end_v     = 1'b0;

    if (eoi) begin
      end_v = 1'b1;
      unique case (mode_r)
        M_INT: begin
          sep_v = sep_bad; pri_v = 1'b1; pri_fin = 1'b1; fin_sel = F_INT;
        end
        M_DOT: begin
          pri_v = 1'b1; pri_code = E_EOL_RADIX;
        end
        M_FRAC: begin
          sep_v = sep_bad; pri_v = 1'b1; pri_fin = 1'b1; fin_sel = F_FLT;
        end
        M_EMARK, M_SIGN: begin
          pri_v = 1'b1; pri_code = E_EOL_EXP;
        end
        M_EXP: begin
          sep_v = sep_bad; pri_v = 1'b1; pri_fin = 1'b1; fin_sel = F_EXP;
        end
        default: ;
      endcase
    end else begin
      unique case (mode_r)
        M_IDLE: idle_go = 1'b1;
        M_INT: begin
          if (run) begin
            tally_nxt = tally_abs;
            pwd_nxt   = dig;
            if (le) begin
              sep_v = sep_bad; pri_v = 1'b1; pri_fin = 1'b1; fin_sel = F_INT;
            end
          end else begin
            sep_v = sep_bad;
            if (ch == CH_DOT) begin
              mode_nxt = M_DOT;
              if (le) begin
                pri_v = 1'b1; pri_code = E_EOL_RADIX; pri_pos = e1;
              end
            end else begin
              pri_v = 1'b1; pri_fin = 1'b1; fin_sel = F_INT; idle_go = 1'b1;
            end
          end
        end
        M_DOT: begin
          if (dig) begin
            mode_nxt = M_FRAC;
            pwd_nxt  = 1'b1;
            if (le) begin
              pri_v = 1'b1; pri_fin = 1'b1; fin_sel = F_FLT;
            end
          end else begin
            pri_v = 1'b1; pri_code = E_BAD_RADIX; idle_go = 1'b1;
          end
        end
        M_FRAC: begin
          if (run) begin
            tally_nxt = tally_abs;
            pwd_nxt   = dig;
            if (le) begin
              sep_v = sep_bad; pri_v = 1'b1; pri_fin = 1'b1; fin_sel = F_FLT;
            end
          end else begin
            sep_v = sep_bad;
            if ((ch == CH_E_LO) || (ch == CH_E_UP)) begin
              mode_nxt = M_EMARK;
              if (le) begin
                pri_v = 1'b1; pri_code = E_EOL_EXP; pri_pos = e1;
              end
            end else begin
              pri_v = 1'b1; pri_fin = 1'b1; fin_sel = F_FLT; idle_go = 1'b1;
            end
          end
        end
        M_EMARK, M_SIGN: begin
          if ((mode_r == M_EMARK) && ((ch == CH_PLUS) || (ch == CH_MINUS))) begin
            mode_nxt = M_SIGN;
            if (le) begin
              pri_v = 1'b1; pri_code = E_EOL_EXP; pri_pos = e1;
            end
          end else if (dig) begin
            mode_nxt  = M_EXP;
            exps_nxt  = p;
            tally_nxt = '0;
            pwd_nxt   = 1'b1;
            // a single exponent digit never exceeds the limit
            if (le) begin
              pri_v = 1'b1; pri_fin = 1'b1; fin_sel = F_FLT;
            end
          end else begin
            pri_v = 1'b1; pri_code = E_BAD_EXP; idle_go = 1'b1;
          end
        end
        M_EXP: begin
          if (run) begin
            tally_nxt = tally_abs;
            pwd_nxt   = dig;
            if (le) begin
              sep_v = sep_bad; pri_v = 1'b1; pri_fin = 1'b1; fin_sel = F_EXP;
            end
          end else begin
            sep_v = sep_bad; pri_v = 1'b1; pri_fin = 1'b1; fin_sel = F_EXP;
            idle_go = 1'b1;
          end
        end
        M_SKIP: begin
          if (ch == CH_NL) mode_nxt = M_IDLE;
        end
      endcase
    end

    // character seen between tokens
    if (idle_go) begin
      mode_nxt = M_IDLE;
      if (!blank && dig) begin
        mode_nxt  = M_INT;
        ts_nxt    = p;
        tally_nxt = '0;
        pwd_nxt   = 1'b1;
      end else if (!blank && !op_v) begin
        mode_nxt = M_SKIP;
      end
    end

    if (eoi) begin
      mode_nxt  = M_IDLE;
      line_nxt  = LINE_ONE;
      col_nxt   = '0;
      ts_nxt    = '0;
      tally_nxt = '0;
      pwd_nxt   = 1'b0;
      exps_nxt  = '0;
    end else if (le) begin
      mode_nxt = M_IDLE;
      col_nxt  = '0;
      line_nxt = (line_r == LINE_MAX) ? line_r : LINE_W'(line_r + 1'b1);
    end else begin
      col_nxt = e1;
    end
  end

  // result beats
  always_comb begin
    r_sep = mk_res(1'b1, KIND_NONE, E_SEPARATOR, line_r, ep, '0);

    unique case (fin_sel)
      F_INT: r_fin = int_big ? mk_res(1'b1, KIND_NONE, E_TOO_LARGE, line_r, ts_r, '0)
                             : mk_res(1'b0, K_INTEGER, CODE_NONE, line_r,
                                      col_inc(ts_r), fin_len);
      F_EXP: r_fin = exp_big ? mk_res(1'b1, KIND_NONE, E_TOO_LARGE, line_r, exps_r, '0)
                             : mk_res(1'b0, K_FLOAT, CODE_NONE, line_r,
                                      col_inc(ts_r), fin_len);
      default: r_fin = mk_res(1'b0, K_FLOAT, CODE_NONE, line_r, col_inc(ts_r), fin_len);
    endcase

    r_pri = pri_fin ? r_fin : mk_res(1'b1, KIND_NONE, pri_code, line_r, pri_pos, '0);

    // a digit at a line end is a one-digit integer right away
    idle_v = !blank && (op_v || !dig || le);
    if (op_v) begin
      r_idle = mk_res(1'b0, op_kind, CODE_NONE, line_r, e1, COL_W'(1));
    end else if (dig) begin
      r_idle = mk_res(1'b0, K_INTEGER, CODE_NONE, line_r, e1, COL_W'(e1 - p));
    end else begin
      r_idle = mk_res(1'b1, KIND_NONE, E_UNRECOGNIZED, line_r, p, '0);
    end

    tail_v = end_v || (idle_go && idle_v);
    r_tail = end_v ? mk_res(1'b0, K_END, CODE_NONE, line_r, COL_W'(1), '0) : r_idle;

    // pack present beats in order
    res[0] = sep_v ? r_sep : (pri_v ? r_pri : r_tail);
    res[1] = (sep_v && pri_v) ? r_pri : r_tail;
    res[2] = r_tail;
    res_n  = CNT_W'(sep_v) + CNT_W'(pri_v) + CNT_W'(tail_v);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      line_r  <= LINE_ONE;
      col_r   <= '0;
      ts_r    <= '0;
      tally_r <= '0;
      pwd_r   <= 1'b0;
      exps_r  <= '0;
    end else if (in_fire) begin
      mode_r  <= mode_nxt;
      line_r  <= line_nxt;
      col_r   <= col_nxt;
      ts_r    <= ts_nxt;
      tally_r <= tally_nxt;
      pwd_r   <= pwd_nxt;
      exps_r  <= exps_nxt;
    end
  end

  a_line_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && le && !eoi |=> (mode_r == M_IDLE) && (col_r == '0))
    else $error("line end did not return scanner to column zero");

  a_eoi_resets: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && eoi |=> (line_r == LINE_ONE) && (mode_r == M_IDLE) && (tally_r == '0))
    else $error("end of input did not reset scanner state");

  a_eoi_one_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && eoi |-> (res_n != '0) && (res[res_n - 1'b1].kind == K_END))
    else $error("end of input without closing end token");

endmodule

// ----- sv/aet_outq.sv -----
// aet_outq: result register for up to three beats per character, drained one
// beat per cycle while out_tready is high onto the output stream; depends on aet_pkg
module aet_outq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      load,
  input  aet_pkg::res_t             res [aet_pkg::MAX_RES],
  input  logic [aet_pkg::CNT_W-1:0] res_n,
  output logic                      take_ok,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [aet_pkg::DATA_W-1:0] out_tdata,
  output logic                      out_tlast
);
  import aet_pkg::*;

  res_t             res_q [MAX_RES];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;

  assign out_tvalid = (idx_r != cnt_r);
  assign out_tlast  = (CNT_W'(idx_r + 1'b1) == cnt_r);
  assign out_tdata  = res_q[idx_r];
  // new beats may load when none are pending or the last pending one leaves this cycle
  assign take_ok    = !out_tvalid || (out_tlast && out_tready);

  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (load) begin
      cnt_nxt = res_n;
      idx_nxt = '0;
    end else if (out_tvalid && out_tready) begin
      idx_nxt = CNT_W'(idx_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res;
    end
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= cnt_r)
    else $error("drain index ran past beat count");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !out_tvalid || (out_tready && out_tlast))
    else $error("pending result beats overwritten");

  a_keep_draining: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("result beats lost inside a group");

endmodule

// ----- sv/arith_expression_tokenizer_core.sv -----
// arith_expression_tokenizer_core: top level of the arithmetic expression
// tokenizer; holds the digit limit registers, uses aet_pkg, aet_lexer, aet_outq
//
// usage:
//  - in_*: one source byte per beat; in_tlast marks the last byte of a line,
//    in_tuser marks end of input (byte and in_tlast are then ignored)
//  - out_*: token and error beats; out_tlast marks the last beat caused by
//    one input beat (input beats that cause nothing give no output beat)
//  - cfg_*: write-only digit limits, written while the stream is idle
//  - output: first result beat valid in the cycle after the input beat is taken
//  - throughput: one input beat per cycle while each makes at most one
//    result and out_tready is high; a beat making more results holds the
//    input until its last beat leaves the result register on the single output port
//  - out_tready low holds the result register and, while any beat is
//    pending, also holds in_tready low; no beat is dropped
//  - reset: scanner idle at line 1 column 0, limits back to 18 and 3,
//    result register empty
module arith_expression_tokenizer_core (
  input  logic                       clk,
  input  logic                       rst_n,
  // input stream
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // ch
  input  logic                       in_tlast,   // line_end
  input  logic                       in_tuser,   // end_of_input
  // result stream
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // is_error[0], kind[4:1], error_code[7:5], line_number[23:8],
  // column[35:24], length[47:36]
  output logic [aet_pkg::DATA_W-1:0] out_tdata,
  output logic                       out_tlast,  // last
  // configuration writes
  input  logic                       cfg_we,
  input  logic [aet_pkg::ADDR_W-1:0] cfg_addr,
  input  logic [aet_pkg::ILIM_W-1:0] cfg_wdata
);
  import aet_pkg::*;

  logic [ILIM_W-1:0] int_lim_r;
  logic [ELIM_W-1:0] exp_lim_r;
  logic              in_fire;
  logic              take_ok;
  res_t              res [MAX_RES];
  logic [CNT_W-1:0]  res_n;

  assign in_tready = take_ok;
  assign in_fire   = in_tvalid && take_ok;

  // digit limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_lim_r <= INT_LIMIT_RST;
      exp_lim_r <= EXP_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_INT_LIMIT: int_lim_r <= cfg_wdata;
        REG_EXP_LIMIT: exp_lim_r <= cfg_wdata[ELIM_W-1:0];
      endcase
    end
  end

  // scanner state and per-character decode
  aet_lexer u_lexer (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .ch      (in_tdata),
    .le      (in_tlast),
    .eoi     (in_tuser),
    .int_lim (int_lim_r),
    .exp_lim (exp_lim_r),
    .res     (res),
    .res_n   (res_n)
  );

  // result register and output drain
  aet_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_fire),
    .res        (res),
    .res_n      (res_n),
    .take_ok    (take_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
